/* hw/rtl/mrvs_pkg.sv */
// Shared types and constants for the mesh route and VC select block.
package mrvs_pkg;

    localparam int BUFFER_CAPACITY = 16;
    localparam int COORD_W = 4;
    localparam int FS_W = 8;
    localparam int LEN_W = 8;
    localparam int LINK_W = 2;
    localparam int NUM_LINKS = 4;
    localparam int NUM_ENTRIES = 8;
    localparam int ENTRY_W = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [FS_W-1:0] FS_CAP = FS_W'(BUFFER_CAPACITY);

    localparam logic [LINK_W-1:0] LINK_XNEG = 2'd0;
    localparam logic [LINK_W-1:0] LINK_XPOS = 2'd1;
    localparam logic [LINK_W-1:0] LINK_YNEG = 2'd2;
    localparam logic [LINK_W-1:0] LINK_YPOS = 2'd3;

    localparam logic VC_ONE = 1'b0;
    localparam logic VC_TWO = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_NODE_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NODE_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MSG_LEN = 2'd2;

    localparam logic [LEN_W-1:0] MSG_LEN_RESET = 8'd4;

    typedef enum logic [1:0] {
        ACT_ROUTE  = 2'd0,
        ACT_CREDIT = 2'd1,
        ACT_CLEAR  = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        ST_GRANTED = 2'd0,
        ST_BLOCKED = 2'd1,
        ST_AT_DEST = 2'd2,
        ST_ACK     = 2'd3
    } status_t;

    typedef struct packed {
        logic [1:0]         action;
        logic [COORD_W-1:0] dst_x;
        logic [COORD_W-1:0] dst_y;
        logic [LINK_W-1:0]  credit_link;
        logic               credit_vc;
        logic [FS_W-1:0]    credit_amount;
    } req_t;

    typedef struct packed {
        status_t           status;
        logic [LINK_W-1:0] out_link;
        logic              out_vc;
    } res_t;

    typedef struct packed {
        logic [COORD_W-1:0] node_x;
        logic [COORD_W-1:0] node_y;
        logic [LEN_W-1:0]   msg_len;
    } cfg_t;

endpackage

/* hw/rtl/mrvs_engine.sv */
// Link/VC allocation logic with free-space counters and link busy flags.
module mrvs_engine (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          fire,
    input  mrvs_pkg::req_t req,
    input  mrvs_pkg::cfg_t cfg,
    output mrvs_pkg::res_t res
);
    import mrvs_pkg::*;

    logic [NUM_LINKS-1:0] busy_reg, busy_next;
    logic [FS_W-1:0]      fs_reg [NUM_ENTRIES];
    logic [FS_W-1:0]      fs_next [NUM_ENTRIES];

    logic [NUM_ENTRIES-1:0] pass;
    logic                   x_pos, y_pos, x_zero, y_zero;
    logic [LINK_W-1:0]      xl, yl;
    logic                   yv;
    logic                   ok_x1, ok_x2, ok_y;
    logic                   grant;
    logic [ENTRY_W-1:0]     gidx, cidx;
    logic [FS_W:0]          csum;

    always_comb begin
        for (int i = 0; i < NUM_ENTRIES; i++) begin
            pass[i] = fs_reg[i] >= cfg.msg_len;
        end
    end

    assign x_pos  = req.dst_x > cfg.node_x;
    assign y_pos  = req.dst_y > cfg.node_y;
    assign x_zero = req.dst_x == cfg.node_x;
    assign y_zero = req.dst_y == cfg.node_y;
    assign xl     = x_pos ? LINK_XPOS : LINK_XNEG;
    assign yl     = y_pos ? LINK_YPOS : LINK_YNEG;
    assign yv     = y_pos ? VC_ONE : VC_TWO;

    assign ok_x1 = !x_zero && !busy_reg[xl] && pass[{xl, VC_ONE}];
    assign ok_x2 = !x_zero && !busy_reg[xl] && pass[{xl, VC_TWO}];
    assign ok_y  = !y_zero && !busy_reg[yl] && pass[{yl, yv}];

    assign cidx = {req.credit_link, req.credit_vc};
    assign csum = {1'b0, fs_reg[cidx]} + {1'b0, req.credit_amount};

    always_comb begin
        res.status   = ST_ACK;
        res.out_link = LINK_XNEG;
        res.out_vc   = VC_ONE;
        grant        = 1'b0;
        unique case (req.action)
            ACT_ROUTE: begin
                if (x_zero && y_zero) begin
                    res.status = ST_AT_DEST;
                end else if (ok_x1) begin
                    res.status   = ST_GRANTED;
                    res.out_link = xl;
                    res.out_vc   = VC_ONE;
                    grant        = 1'b1;
                end else if (ok_x2) begin
                    res.status   = ST_GRANTED;
                    res.out_link = xl;
                    res.out_vc   = VC_TWO;
                    grant        = 1'b1;
                end else if (ok_y) begin
                    res.status   = ST_GRANTED;
                    res.out_link = yl;
                    res.out_vc   = yv;
                    grant        = 1'b1;
                end else begin
                    res.status = ST_BLOCKED;
                end
            end
            default: begin
            end
        endcase
    end

    assign gidx = {res.out_link, res.out_vc};

    always_comb begin
        busy_next = busy_reg;
        for (int i = 0; i < NUM_ENTRIES; i++) begin
            fs_next[i] = fs_reg[i];
        end
        if (fire) begin
            if (grant) begin
                busy_next[res.out_link] = 1'b1;
            end
            if (req.action == ACT_CLEAR) begin
                busy_next = '0;
            end
            for (int i = 0; i < NUM_ENTRIES; i++) begin
                if (grant && gidx == ENTRY_W'(i)) begin
                    fs_next[i] = fs_reg[i] - cfg.msg_len;
                end else if (req.action == ACT_CREDIT && cidx == ENTRY_W'(i)) begin
                    fs_next[i] = (csum > {1'b0, FS_CAP}) ? FS_CAP : csum[FS_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= '0;
            for (int i = 0; i < NUM_ENTRIES; i++) begin
                fs_reg[i] <= FS_CAP;
            end
        end else begin
            busy_reg <= busy_next;
            for (int i = 0; i < NUM_ENTRIES; i++) begin
                fs_reg[i] <= fs_next[i];
            end
        end
    end

    a_grant_sets_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && grant |=> busy_reg[$past(res.out_link)])
        else $error("granted link not marked busy");

    a_grant_was_free: assert property (@(posedge aclk) disable iff (!aresetn)
        grant |-> !busy_reg[res.out_link])
        else $error("grant on a busy link");

    a_clear_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && req.action == ACT_CLEAR |=> busy_reg == '0)
        else $error("busy flags not cleared");

    a_credit_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && req.action == ACT_CREDIT |=> fs_reg[$past(cidx)] <= FS_CAP)
        else $error("credit exceeded capacity");

    a_nogrant_zero: assert property (@(posedge aclk)
        res.status != ST_GRANTED |-> res.out_link == LINK_XNEG && res.out_vc == VC_ONE)
        else $error("link or vc set without grant");

endmodule

/* hw/rtl/mesh_route_vc_select_top.sv */
// Top level: config registers, request input register and result register.
// Output-port and virtual-channel selector for one 2D-mesh router. Each request
// (route, credit return or busy clear) is held in the input register and then in
// the result register; a new request is accepted every cycle while the result
// side keeps up. Allocation is one pass of compares over the eight free-space
// counters and four busy flags, so the sustained rate is one request per cycle
// while the result side keeps up. Write the config registers only while no
// request is in flight.
module mesh_route_vc_select_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [mrvs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mrvs_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [1:0]                        s_action,
    input  logic [mrvs_pkg::COORD_W-1:0]      s_dst_x,
    input  logic [mrvs_pkg::COORD_W-1:0]      s_dst_y,
    input  logic [mrvs_pkg::LINK_W-1:0]       s_credit_link,
    input  logic                              s_credit_vc,
    input  logic [mrvs_pkg::FS_W-1:0]         s_credit_amount,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [1:0]                        m_status,
    output logic [mrvs_pkg::LINK_W-1:0]       m_out_link,
    output logic                              m_out_vc
);
    import mrvs_pkg::*;

    cfg_t cfg_reg;
    logic in_valid_reg;
    req_t in_req_reg;
    logic out_valid_reg;
    res_t out_res_reg;
    res_t res;
    logic advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.node_x  <= '0;
            cfg_reg.node_y  <= '0;
            cfg_reg.msg_len <= MSG_LEN_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_NODE_X:  cfg_reg.node_x  <= cfg_wdata[COORD_W-1:0];
                CFG_NODE_Y:  cfg_reg.node_y  <= cfg_wdata[COORD_W-1:0];
                CFG_MSG_LEN: cfg_reg.msg_len <= cfg_wdata[LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_req_reg <= '{action: s_action, dst_x: s_dst_x, dst_y: s_dst_y,
                            credit_link: s_credit_link, credit_vc: s_credit_vc,
                            credit_amount: s_credit_amount};
        end
        if (advance) begin
            out_res_reg <= res;
        end
    end

    mrvs_engine u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (advance),
        .req     (in_req_reg),
        .cfg     (cfg_reg),
        .res     (res)
    );

    assign m_valid    = out_valid_reg;
    assign m_status   = out_res_reg.status;
    assign m_out_link = out_res_reg.out_link;
    assign m_out_vc   = out_res_reg.out_vc;

    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_ready)
        else $error("stalled with empty input register");

    a_advance_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_valid_reg)
        else $error("request advanced without a result");

    a_no_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_ready |-> !advance)
        else $error("result overwritten before taken");

endmodule
